### sv/gregorian_date_add_days_macros.svh
// Assertion macros used by the checker file gdad_checker.sv.
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// Checked only outside reset.
`define GDAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define GDAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/gdad_pkg.sv
`timescale 1ns / 1ps
package gdad_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DAYS_W  = 16;
  // Low bits of days_to_add that are used; 1 to DAYS_W.
  localparam int ADD_WIDTH = 16;
  // day + count, wide enough for whichever operand is wider
  localparam int TOTAL_W   = ((ADD_WIDTH > DAY_W) ? ADD_WIDTH : DAY_W) + 1;

  // floor(year / 100) as (year * RECIP) >> RECIP_SH, exact for 14-bit years.
  localparam int RECIP    = 5243;
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 19;
  localparam int PROD_W   = YEAR_W + RECIP_W;
  localparam int QUOT_W   = 8;
  localparam int R100_W   = 7;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic load;   // capture input transaction
    logic split;  // year / 100
    logic rem;    // year % 100, century % 4
    logic check;  // validate, form day + count
    logic step;   // take away one month
    logic emit;   // load result register
  } gdad_cmd_t;

  typedef struct packed {
    logic bad;    // starting date invalid
    logic fits;   // running day fits current month
  } gdad_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      MONTH_FEB:                                  len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

### sv/gdad_ctrl.sv
`timescale 1ns / 1ps
module gdad_ctrl
  import gdad_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_stall_i,
  input  gdad_sts_t sts_i,
  output gdad_cmd_t cmd_o,
  output logic      busy_o,
  output logic      out_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SPLIT, S_REM, S_CHECK, S_WALK, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = S_REM;
      end
      S_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad ? S_EMIT : S_WALK;
      end
      S_WALK: begin
        if (sts_i.fits) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/gdad_dp.sv
`timescale 1ns / 1ps
module gdad_dp
  import gdad_pkg::*;
(
  input  logic               clk_i,
  input  gdad_cmd_t          cmd_i,
  input  logic [DAY_W-1:0]   day_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [DAYS_W-1:0]  days_to_add_i,
  output gdad_sts_t          sts_o,
  output logic               date_valid_o,
  output logic [DAY_W-1:0]   new_day_o,
  output logic [MONTH_W-1:0] new_month_o,
  output logic [YEAR_W-1:0]  new_year_o
);

  logic [DAY_W-1:0]     day_q;
  logic [MONTH_W-1:0]   month_q;
  logic [YEAR_W-1:0]    year_q;
  logic [ADD_WIDTH-1:0] add_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [R100_W-1:0]    r100_q;
  logic [1:0]           q4_q;
  logic [TOTAL_W-1:0]   total_q;
  logic                 ok_q;
  logic                 date_valid_q;
  logic [DAY_W-1:0]     new_day_q;
  logic [MONTH_W-1:0]   new_month_q;
  logic [YEAR_W-1:0]    new_year_q;

  logic [PROD_W-1:0]    prod;
  logic [YEAR_W-1:0]    cent;
  logic                 leap;
  logic [DAY_W-1:0]     len;

  assign prod = PROD_W'(year_q) * PROD_W'(RECIP);
  assign cent = YEAR_W'(quot_q) * YEAR_W'(100);

  // Divisible by 4 but not 100, or by 400.
  assign leap = (r100_q[1:0] == 2'b00) && ((r100_q != '0) || (q4_q == 2'b00));
  assign len  = month_len(month_q, leap);

  assign sts_o.bad  = (len == '0) || (day_q == '0) || (day_q > len);
  assign sts_o.fits = (total_q <= TOTAL_W'(len));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q   <= day_i;
      month_q <= month_i;
      year_q  <= year_i;
      add_q   <= days_to_add_i[ADD_WIDTH-1:0];
    end
    if (cmd_i.split) begin
      quot_q <= prod[RECIP_SH +: QUOT_W];
    end
    if (cmd_i.rem) begin
      r100_q <= R100_W'(year_q - cent);
      q4_q   <= quot_q[1:0];
    end
    if (cmd_i.check) begin
      total_q <= TOTAL_W'(day_q) + TOTAL_W'(add_q);
      ok_q    <= !sts_o.bad;
    end
    if (cmd_i.step) begin
      total_q <= total_q - TOTAL_W'(len);
      if (month_q == MONTH_DEC) begin
        month_q <= MONTH_JAN;
        year_q  <= year_q + YEAR_W'(1);
        // Wrap to year 0 restarts the century counters.
        if (year_q == '1) begin
          r100_q <= '0;
          q4_q   <= '0;
        end else if (r100_q == R100_W'(99)) begin
          r100_q <= '0;
          q4_q   <= q4_q + 2'd1;
        end else begin
          r100_q <= r100_q + R100_W'(1);
        end
      end else begin
        month_q <= month_q + MONTH_W'(1);
      end
    end
    if (cmd_i.emit) begin
      date_valid_q <= ok_q;
      new_day_q    <= ok_q ? total_q[DAY_W-1:0] : '0;
      new_month_q  <= ok_q ? month_q : '0;
      new_year_q   <= ok_q ? year_q : '0;
    end
  end

  assign date_valid_o = date_valid_q;
  assign new_day_o    = new_day_q;
  assign new_month_o  = new_month_q;
  assign new_year_o   = new_year_q;

endmodule

### sv/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o   | day, month, year, days_to_add
// out     | output    | out_valid_o / out_stall_i | date_valid, new_day, new_month, new_year
//
// Sequence: a transaction passes through the split, remainder and check states,
//   then a month walk over the M month boundaries crossed (up to about 2155
//   for a 16-bit count), then the emit state; an invalid date skips the walk.
//   The walk retires one month per cycle through one subtract and compare.
// Reset: rst_ni clears the controller and the result valid flag.
// Stalls: a result waits in the output register while out_stall_i is high; a
//   new transaction is taken once the previous one has left the controller.
module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [DAY_W-1:0]   day_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [DAYS_W-1:0]  days_to_add_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               date_valid_o,
  output logic [DAY_W-1:0]   new_day_o,
  output logic [MONTH_W-1:0] new_month_o,
  output logic [YEAR_W-1:0]  new_year_o
);

  gdad_cmd_t cmd;
  gdad_sts_t sts;
  logic      busy;

  // Input is stalled for the whole walk of one transaction.
  assign in_stall_o = busy;

  // Sequencer: split year, validate, walk months, hand off result.
  gdad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  // Date registers, century counters for the leap rule, result register.
  gdad_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .day_i         (day_i),
    .month_i       (month_i),
    .year_i        (year_i),
    .days_to_add_i (days_to_add_i),
    .sts_o         (sts),
    .date_valid_o  (date_valid_o),
    .new_day_o     (new_day_o),
    .new_month_o   (new_month_o),
    .new_year_o    (new_year_o)
  );

endmodule

### sv/gdad_checker.sv
`timescale 1ns / 1ps
`include "gregorian_date_add_days_macros.svh"
module gdad_checker
  import gdad_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [DAY_W-1:0]   day_i,
  input logic [MONTH_W-1:0] month_i,
  input logic [YEAR_W-1:0]  year_i,
  input logic [DAYS_W-1:0]  days_to_add_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               date_valid_o,
  input logic [DAY_W-1:0]   new_day_o,
  input logic [MONTH_W-1:0] new_month_o,
  input logic [YEAR_W-1:0]  new_year_o
);

  logic                             res_zero;
  logic                             res_in_range;
  logic                             out_held;
  logic [DAY_W+MONTH_W+YEAR_W:0]    res_bits;

  assign res_zero     = (new_day_o == '0) && (new_month_o == '0) && (new_year_o == '0);
  assign res_in_range = (new_day_o != '0) && (new_month_o != '0) &&
                        (new_month_o <= MONTH_DEC);
  assign out_held     = out_valid_o && out_stall_i;
  assign res_bits     = {date_valid_o, new_day_o, new_month_o, new_year_o};

  `GDAD_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |=> !out_valid_o, "result valid in reset")

  `GDAD_ASSERT(a_rise_after_work, $rose(out_valid_o) |-> $past(in_stall_o), "result without work")

  `GDAD_ASSERT(a_bad_zero, (out_valid_o && !date_valid_o) |-> res_zero, "invalid date result not zero")

  `GDAD_ASSERT(a_good_range, (out_valid_o && date_valid_o) |-> res_in_range, "valid result out of range")

  `GDAD_ASSERT(a_out_hold, out_held |=> (out_valid_o && $stable(res_bits)), "stalled result changed")

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import gdad_pkg::*;

  // Generous ceiling: every item at the largest count, plus sender gaps
  // and receiver stalls, taken several times over.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int N_DIRECTED   = 22;
  localparam int N_PER_PHASE  = 83;
  localparam int MAX_REPORTED = 10;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [DAYS_W-1:0]  days_to_add;
  } date_req_t;

  typedef struct packed {
    logic               date_valid;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_res_t;

  // typed = 1: the expected date is written in the row, else it is predicted.
  typedef struct packed {
    date_req_t req;
    logic      typed;
    date_res_t res;
  } date_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [DAY_W-1:0]   day_i = '0;
  logic [MONTH_W-1:0] month_i = '0;
  logic [YEAR_W-1:0]  year_i = '0;
  logic [DAYS_W-1:0]  days_to_add_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               date_valid_o;
  logic [DAY_W-1:0]   new_day_o;
  logic [MONTH_W-1:0] new_month_o;
  logic [YEAR_W-1:0]  new_year_o;

  date_res_t   expected_dates[$];
  date_row_t   date_table[N_DIRECTED];
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 73;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  gregorian_date_add_days uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .day_i        (day_i),
    .month_i      (month_i),
    .year_i       (year_i),
    .days_to_add_i(days_to_add_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .date_valid_o (date_valid_o),
    .new_day_o    (new_day_o),
    .new_month_o  (new_month_o),
    .new_year_o   (new_year_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Month length in the Gregorian calendar; 0 marks a month out of range.
  function automatic int unsigned month_days(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
      MONTH_FEB:                                  return leap ? 29 : 28;
      default:                                    return 0;
    endcase
  endfunction

  // Predicted date: validate, add the count to the day, then peel off
  // whole months until the day fits. The year wraps at 14 bits.
  function automatic date_res_t add_days_to_date(date_req_t r);
    date_res_t          res;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [DAYS_W-1:0]  used;
    int unsigned        len;
    int unsigned        total;
    res  = '0;
    m    = r.month;
    y    = r.year;
    used = r.days_to_add & DAYS_W'((64'd1 << ADD_WIDTH) - 64'd1);
    len  = month_days(m, y);
    if (len == 0 || r.day == 0 || r.day > len) return res;
    total = r.day + used;
    while (total > len) begin
      total -= len;
      if (m == MONTH_DEC) begin
        m = MONTH_JAN;
        y = y + 1'b1;
      end else begin
        m = m + 1'b1;
      end
      len = month_days(m, y);
    end
    res.date_valid = 1'b1;
    res.day        = DAY_W'(total);
    res.month      = m;
    res.year       = y;
    return res;
  endfunction

  // Mostly calendar dates with random content; about one in seven is raw
  // noise over the whole field range (bad months, day 0, day past month end).
  // Counts are mostly short so the month walk stays cheap; a few use the
  // full 16 bits or sit at or just below the maximum.
  function automatic date_req_t random_date();
    date_req_t   r;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.day   = DAY_W'($urandom);
      r.month = MONTH_W'($urandom);
      r.year  = YEAR_W'($urandom);
    end else begin
      r.month = MONTH_W'($urandom_range(1, 12));
      pick    = $urandom_range(0, 99);
      if (pick < 70)      r.year = YEAR_W'($urandom_range(0, 9999));
      else if (pick < 85) r.year = YEAR_W'($urandom_range(0, 16383));
      else if (pick < 93) r.year = YEAR_W'(16383 - $urandom_range(0, 3));
      else                r.year = YEAR_W'($urandom_range(0, 99) * 100);
      len  = month_days(r.month, r.year);
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.day = DAY_W'(len);
      else if (pick < 35) r.day = DAY_W'(len + 1);
      else                r.day = DAY_W'($urandom_range(1, len));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60)      r.days_to_add = DAYS_W'($urandom_range(0, 400));
    else if (pick < 85) r.days_to_add = DAYS_W'($urandom_range(0, 4000));
    else if (pick < 95) r.days_to_add = DAYS_W'($urandom);
    else                r.days_to_add = DAYS_W'(65535 - $urandom_range(0, 1));
    return r;
  endfunction

  // One input transaction: random idle cycles at the falling edge, then hold
  // valid and payload until the block takes it at a rising edge.
  task automatic offer_date(date_req_t r, date_res_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    day_i         <= r.day;
    month_i       <= r.month;
    year_i        <= r.year;
    days_to_add_i <= r.days_to_add;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_dates.push_back(want);
  endtask

  // Receiver stalls, redrawn each falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result checker: each output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    date_res_t got;
    date_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{date_valid_o, new_day_o, new_month_o, new_year_o};
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("unexpected result: valid=%0d %0d/%0d/%0d", got.date_valid,
                   got.day, got.month, got.year);
      end else begin
        want = expected_dates.pop_front();
        if (got.date_valid !== want.date_valid || got.day !== want.day ||
            got.month !== want.month || got.year !== want.year) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("date mismatch: expected valid=%0d %0d/%0d/%0d, got valid=%0d %0d/%0d/%0d",
                     want.date_valid, want.day, want.month, want.year,
                     got.date_valid, got.day, got.month, got.year);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    date_row_t row;
    date_req_t r;
    // day/month/year + count, typed flag, expected valid/day/month/year
    date_table = '{
      '{'{5'd1,  4'd1,  14'd2000,  16'd0},     1'b1, '{1'b1, 5'd1,  4'd1, 14'd2000}},
      '{'{5'd31, 4'd12, 14'd9999,  16'd1},     1'b1, '{1'b1, 5'd1,  4'd1, 14'd10000}},
      // December rollover past the top of the 14-bit year
      '{'{5'd31, 4'd12, 14'd16383, 16'd1},     1'b1, '{1'b1, 5'd1,  4'd1, 14'd0}},
      // year zero is a leap year
      '{'{5'd28, 4'd2,  14'd0,     16'd1},     1'b1, '{1'b1, 5'd29, 4'd2, 14'd0}},
      '{'{5'd29, 4'd2,  14'd1900,  16'd0},     1'b1, '0},
      '{'{5'd29, 4'd2,  14'd2000,  16'd0},     1'b1, '{1'b1, 5'd29, 4'd2, 14'd2000}},
      '{'{5'd29, 4'd2,  14'd2023,  16'd5},     1'b1, '0},
      '{'{5'd0,  4'd5,  14'd2020,  16'd3},     1'b1, '0},
      '{'{5'd31, 4'd4,  14'd2021,  16'd0},     1'b1, '0},
      '{'{5'd1,  4'd0,  14'd2020,  16'd1},     1'b1, '0},
      '{'{5'd1,  4'd13, 14'd2020,  16'd1},     1'b1, '0},
      '{'{5'd31, 4'd15, 14'd16383, 16'd65535}, 1'b1, '0},
      '{'{5'd31, 4'd0,  14'd0,     16'd0},     1'b1, '0},
      '{'{5'd15, 4'd8,  14'd1999,  16'd0},     1'b1, '{1'b1, 5'd15, 4'd8, 14'd1999}},
      '{'{5'd1,  4'd1,  14'd0,     16'd0},     1'b1, '{1'b1, 5'd1,  4'd1, 14'd0}},
      '{'{5'd1,  4'd1,  14'd2000,  16'd65535}, 1'b0, '0},
      '{'{5'd31, 4'd12, 14'd16383, 16'd65535}, 1'b0, '0},
      '{'{5'd28, 4'd2,  14'd2100,  16'd1},     1'b0, '0},
      '{'{5'd31, 4'd1,  14'd2024,  16'd29},    1'b0, '0},
      '{'{5'd30, 4'd6,  14'd2004,  16'd366},   1'b0, '0},
      '{'{5'd31, 4'd12, 14'd2399,  16'd60},    1'b0, '0},
      '{'{5'd31, 4'd1,  14'd16383, 16'd20000}, 1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows run with the first idling mix.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = date_table[i];
      offer_date(row.req, row.typed ? row.res : add_days_to_date(row.req));
    end

    // Random transactions in three idling phases: sender light / receiver
    // heavy, then swapped, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 31 : 0;
      for (int i = 0; i < N_PER_PHASE; i++) begin
        r = random_date();
        offer_date(r, add_days_to_date(r));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/gdad_pkg.sv
sv/gdad_ctrl.sv
sv/gdad_dp.sv
sv/gregorian_date_add_days.sv
sv/gdad_checker.sv
tb/tb.sv
